// ===== rtl/xa_adpcm_sample_decoder_defines.svh =====
// Assertion macros shared by the XA-ADPCM sample decoder RTL.
`ifndef XA_ADPCM_SAMPLE_DECODER_DEFINES_SVH
`define XA_ADPCM_SAMPLE_DECODER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define XAD_CHECK_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define XAD_CHECK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/xad_pkg.sv =====
// Shared types, constants and coefficient tables of the XA-ADPCM sample decoder.
package xad_pkg;

   localparam int unsigned SampleW   = 16;
   localparam int unsigned CoefW     = 8;
   localparam int unsigned ProdW     = SampleW + CoefW;
   localparam int unsigned PredSumW  = ProdW + 1;
   localparam int unsigned DivShift  = 6;
   localparam int unsigned PredQW    = PredSumW - DivShift;
   localparam int unsigned TotalW    = PredQW + 1;
   localparam int unsigned HistDepth = 2;

   localparam int RoundBias = 32;

   localparam logic [3:0] ShiftLarge  = 4'd13;
   localparam logic [3:0] ShiftCapped = 4'd9;

   localparam logic signed [SampleW-1:0] SampleMax = 16'sh7FFF;
   localparam logic signed [SampleW-1:0] SampleMin = -16'sh8000;

   localparam logic [1:0] ChanLeft  = 2'd0;
   localparam logic [1:0] ChanRight = 2'd1;
   localparam logic [1:0] ChanBoth  = 2'd2;

   localparam int unsigned CsrIndexW = 1;
   localparam int unsigned CsrDataW  = 1;
   localparam logic [CsrIndexW-1:0] CsrStereo   = 1'b0;
   localparam logic [CsrIndexW-1:0] CsrEightBit = 1'b1;

   localparam int unsigned QueueDepth = 2;
   localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
   localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic signed [SampleW-1:0] scaled;   // code after header shift
      logic [1:0]                filter;
      logic [1:0]                chan;
   } xad_item_type;

   function automatic logic signed [CoefW-1:0] pos_coef(input logic [1:0] filter);
      logic signed [CoefW-1:0] c;
      case (filter)
         2'd0: c = 8'sd0;
         2'd1: c = 8'sd60;
         2'd2: c = 8'sd115;
         2'd3: c = 8'sd98;
         default: c = 8'sd0;
      endcase
      return c;
   endfunction

   function automatic logic signed [CoefW-1:0] neg_coef(input logic [1:0] filter);
      logic signed [CoefW-1:0] c;
      case (filter)
         2'd2: c = -8'sd52;
         2'd3: c = -8'sd55;
         default: c = 8'sd0;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/xad_req_if.sv =====
// Input channel of the XA-ADPCM sample decoder: one coded sample per beat.
interface xad_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic [2:0]  unit_index;
   logic [7:0]  unit_header;

   modport source (output valid, output data_word, output unit_index, output unit_header,
                   input ready);
   modport sink (input valid, input data_word, input unit_index, input unit_header,
                 output ready);
endinterface

// ===== rtl/xad_rsp_if.sv =====
// Result channel of the XA-ADPCM sample decoder: one PCM sample per beat.
interface xad_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample_value;
   logic [1:0]         channel_tag;

   modport source (output valid, output sample_value, output channel_tag, input ready);
   modport sink (input valid, input sample_value, input channel_tag, output ready);
endinterface

// ===== rtl/xa_adpcm_sample_decoder.sv =====
// XA-ADPCM sample decoder: one beat in gives one PCM sample out. Sustained rate is one beat per
// cycle while the output is not stalled; an accepted beat is written into the queue and is loaded
// into the result register when the output is not stalled. The front end registers the mode bits,
// extracts and shifts the code and tags its channel; a two-entry queue decouples it from the back
// end, whose loop (history, two constant-coefficient multiplies, rounding, saturation, history
// update) sets that rate, shared by both channels. Mode writes are expected only while idle.
module xa_adpcm_sample_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [xad_pkg::CsrIndexW-1:0] csr_index,
   input  logic [xad_pkg::CsrDataW-1:0]  csr_wr_data,
   xad_req_if.sink                       req_chan,
   xad_rsp_if.source                     rsp_chan
);
   import xad_pkg::*;

   xad_item_type push_item;
   xad_item_type head_item;
   logic         push;
   logic         pop;
   logic         not_empty;
   logic         full;

   xad_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req         (req_chan),
      .q_full      (full),
      .q_push      (push),
      .q_item      (push_item)
   );

   xad_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .not_empty (not_empty),
      .full      (full)
   );

   xad_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (not_empty),
      .q_item  (head_item),
      .q_pop   (pop),
      .rsp     (rsp_chan)
   );

endmodule

// ===== rtl/xad_front.sv =====
// Front end: mode registers, code extraction, header shift and channel routing.
module xad_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [xad_pkg::CsrIndexW-1:0] csr_index,
   input  logic [xad_pkg::CsrDataW-1:0]  csr_wr_data,
   xad_req_if.sink                       req,
   input  logic                          q_full,
   output logic                          q_push,
   output xad_pkg::xad_item_type         q_item
);
   import xad_pkg::*;

   logic                      stereo_ff, stereo_in;
   logic                      eight_bit_ff, eight_bit_in;
   logic [3:0]                shift_amt;
   logic [3:0]                nibble;
   logic [7:0]                code_byte;
   logic signed [SampleW-1:0] raw;

   always_comb begin
      stereo_in    = stereo_ff;
      eight_bit_in = eight_bit_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CsrStereo:   stereo_in    = csr_wr_data[0];
            CsrEightBit: eight_bit_in = csr_wr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stereo_ff    <= 1'b0;
         eight_bit_ff <= 1'b0;
      end else begin
         stereo_ff    <= stereo_in;
         eight_bit_ff <= eight_bit_in;
      end
   end

   always_comb begin
      shift_amt = req.unit_header[3:0];
      if (shift_amt >= ShiftLarge) begin
         shift_amt = ShiftCapped;
      end
      nibble    = req.data_word[{req.unit_index, 2'b00} +: 4];
      // byte mode: units 4..7 wrap onto bytes 0..3
      code_byte = req.data_word[{req.unit_index[1:0], 3'b000} +: 8];
      raw       = eight_bit_ff ? {code_byte, 8'h00} : {nibble, 12'h000};

      q_item.scaled = raw >>> shift_amt;
      q_item.filter = req.unit_header[5:4];
      if (!stereo_ff) begin
         q_item.chan = ChanBoth;
      end else if (req.unit_index[0]) begin
         q_item.chan = ChanRight;
      end else begin
         q_item.chan = ChanLeft;
      end
   end

   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

endmodule

// ===== rtl/xad_queue.sv =====
// Short register queue between the front end and the prediction back end.
`include "xa_adpcm_sample_decoder_defines.svh"

module xad_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  xad_pkg::xad_item_type push_item,
   input  logic                  pop,
   output xad_pkg::xad_item_type head_item,
   output logic                  not_empty,
   output logic                  full
);
   import xad_pkg::*;

   xad_item_type         slot_ff [QueueDepth];
   logic [QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0] count_ff, count_in;

   function automatic logic [QueuePtrW-1:0] ptr_next(input logic [QueuePtrW-1:0] p);
      logic [QueuePtrW-1:0] n;
      if (p == QueuePtrW'(QueueDepth - 1)) begin
         n = '0;
      end else begin
         n = p + QueuePtrW'(1);
      end
      return n;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QueueCntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QueueCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == QueueCntW'(QueueDepth));

   `XAD_CHECK_NOW(a_queue_bound, clock, reset, 1'b1, count_ff <= QueueCntW'(QueueDepth), "queue count above depth")
   `XAD_CHECK_NOW(a_pop_not_empty, clock, reset, pop, count_ff != '0, "pop from empty queue")
   `XAD_CHECK_NOW(a_push_not_full, clock, reset, push, !full, "push into full queue")

endmodule

// ===== rtl/xad_back.sv =====
// Back end: history prediction, saturation, history update and result register.
`include "xa_adpcm_sample_decoder_defines.svh"

module xad_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  xad_pkg::xad_item_type q_item,
   output logic                  q_pop,
   xad_rsp_if.source             rsp
);
   import xad_pkg::*;

   logic signed [SampleW-1:0]  hl_ff [HistDepth];
   logic signed [SampleW-1:0]  hl_in [HistDepth];
   logic signed [SampleW-1:0]  hr_ff [HistDepth];
   logic signed [SampleW-1:0]  hr_in [HistDepth];
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SampleW-1:0]  sample_ff;
   logic [1:0]                 chan_ff;

   logic signed [SampleW-1:0]  h0, h1;
   logic signed [ProdW-1:0]    prod_pos, prod_neg;
   logic signed [PredSumW-1:0] pred_sum;
   logic signed [PredQW-1:0]   pred_q;
   logic signed [TotalW-1:0]   total;
   logic signed [SampleW-1:0]  sample;

   assign q_pop = q_valid && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      h0 = (q_item.chan == ChanRight) ? hr_ff[0] : hl_ff[0];
      h1 = (q_item.chan == ChanRight) ? hr_ff[1] : hl_ff[1];
      prod_pos = h0 * pos_coef(q_item.filter);
      prod_neg = h1 * neg_coef(q_item.filter);
      pred_sum = PredSumW'(prod_pos) + PredSumW'(prod_neg) + PredSumW'(RoundBias);
      // divide by 64, truncating toward zero
      pred_q = $signed(pred_sum[PredSumW-1:DivShift]);
      if (pred_sum[PredSumW-1] && (pred_sum[DivShift-1:0] != '0)) begin
         pred_q = pred_q + PredQW'(1);
      end
      total = TotalW'(q_item.scaled) + TotalW'(pred_q);
      if (total > TotalW'(SampleMax)) begin
         sample = SampleMax;
      end else if (total < TotalW'(SampleMin)) begin
         sample = SampleMin;
      end else begin
         sample = total[SampleW-1:0];
      end
   end

   always_comb begin
      hl_in = hl_ff;
      hr_in = hr_ff;
      if (q_pop) begin
         case (q_item.chan)
            ChanLeft: begin
               hl_in[1] = hl_ff[0];
               hl_in[0] = sample;
            end
            ChanRight: begin
               hr_in[1] = hr_ff[0];
               hr_in[0] = sample;
            end
            ChanBoth: begin
               hl_in[1] = hl_ff[0];
               hl_in[0] = sample;
               hr_in[1] = hr_ff[0];
               hr_in[0] = sample;
            end
            default: ;
         endcase
      end
      rsp_valid_in = q_pop || (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hl_ff[0]     <= '0;
         hl_ff[1]     <= '0;
         hr_ff[0]     <= '0;
         hr_ff[1]     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hl_ff        <= hl_in;
         hr_ff        <= hr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         sample_ff <= sample;
         chan_ff   <= q_item.chan;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.sample_value = sample_ff;
   assign rsp.channel_tag  = chan_ff;

   `XAD_CHECK_NEXT(a_pop_loads_out, clock, reset, q_pop, rsp_valid_ff && sample_ff == hl_ff[0] || rsp_valid_ff && sample_ff == hr_ff[0], "result does not match newest history")
   `XAD_CHECK_NEXT(a_mono_hist_match, clock, reset, q_pop && q_item.chan == ChanBoth, hl_ff[0] == hr_ff[0], "mono beat left histories apart")
   `XAD_CHECK_NEXT(a_hist_hold, clock, reset, !q_pop, $stable(hl_ff[0]) && $stable(hr_ff[0]), "history moved without a beat")

endmodule
